/* sv/ntc_pkg.sv */
// ntc_pkg: shared constants, types and the resistance table for the thermistor block
// no dependencies
`timescale 1ns / 1ps
package ntc_pkg;
    localparam int SamplesPerAverage = 16;
    localparam int TableEntries      = 111;
    localparam int TableStored       = 111;
    localparam logic [13:0] ColdLimit = 14'd9297;
    localparam logic [13:0] HotLimit  = 14'd114;
    localparam logic [9:0]  OpenLimitReset = 10'd1000;
    localparam logic [15:0] PullupReset    = 16'd1594;
    localparam logic [0:0]  RegOpenLimit = 1'd0;
    localparam logic [0:0]  RegPullup    = 1'd1;

    // averaged sample handed from front to back
    typedef struct packed {
        logic [9:0] avg;
        logic       working;
    } job_t;

    function automatic logic [13:0] table_value(input logic [7:0] idx);
        logic [13:0] v;
        unique case (idx)
            8'd0: v = 14'd9297; 8'd1: v = 14'd8822; 8'd2: v = 14'd8372; 8'd3: v = 14'd7950;
            8'd4: v = 14'd7550; 8'd5: v = 14'd7172; 8'd6: v = 14'd6816; 8'd7: v = 14'd6478;
            8'd8: v = 14'd6159; 8'd9: v = 14'd5859; 8'd10: v = 14'd5575; 8'd11: v = 14'd5297;
            8'd12: v = 14'd5034; 8'd13: v = 14'd4784; 8'd14: v = 14'd4550; 8'd15: v = 14'd4325;
            8'd16: v = 14'd4116; 8'd17: v = 14'd3916; 8'd18: v = 14'd3728; 8'd19: v = 14'd3547;
            8'd20: v = 14'd3378; 8'd21: v = 14'd3222; 8'd22: v = 14'd3073; 8'd23: v = 14'd2933;
            8'd24: v = 14'd2799; 8'd25: v = 14'd2672; 8'd26: v = 14'd2552; 8'd27: v = 14'd2438;
            8'd28: v = 14'd2329; 8'd29: v = 14'd2226; 8'd30: v = 14'd2128; 8'd31: v = 14'd2035;
            8'd32: v = 14'd1947; 8'd33: v = 14'd1863; 8'd34: v = 14'd1783; 8'd35: v = 14'd1707;
            8'd36: v = 14'd1633; 8'd37: v = 14'd1564; 8'd38: v = 14'd1497; 8'd39: v = 14'd1434;
            8'd40: v = 14'd1374; 8'd41: v = 14'd1317; 8'd42: v = 14'd1262; 8'd43: v = 14'd1210;
            8'd44: v = 14'd1160; 8'd45: v = 14'd1113; 8'd46: v = 14'd1068; 8'd47: v = 14'd1025;
            8'd48: v = 14'd983;  8'd49: v = 14'd945;  8'd50: v = 14'd907;  8'd51: v = 14'd871;
            8'd52: v = 14'd837;  8'd53: v = 14'd804;  8'd54: v = 14'd773;  8'd55: v = 14'd743;
            8'd56: v = 14'd715;  8'd57: v = 14'd688;  8'd58: v = 14'd662;  8'd59: v = 14'd637;
            8'd60: v = 14'd613;  8'd61: v = 14'd590;  8'd62: v = 14'd569;  8'd63: v = 14'd548;
            8'd64: v = 14'd528;  8'd65: v = 14'd508;  8'd66: v = 14'd489;  8'd67: v = 14'd472;
            8'd68: v = 14'd454;  8'd69: v = 14'd438;  8'd70: v = 14'd422;  8'd71: v = 14'd407;
            8'd72: v = 14'd393;  8'd73: v = 14'd378;  8'd74: v = 14'd365;  8'd75: v = 14'd353;
            8'd76: v = 14'd340;  8'd77: v = 14'd328;  8'd78: v = 14'd317;  8'd79: v = 14'd306;
            8'd80: v = 14'd296;  8'd81: v = 14'd286;  8'd82: v = 14'd276;  8'd83: v = 14'd267;
            8'd84: v = 14'd258;  8'd85: v = 14'd250;  8'd86: v = 14'd241;  8'd87: v = 14'd233;
            8'd88: v = 14'd226;  8'd89: v = 14'd219;  8'd90: v = 14'd211;  8'd91: v = 14'd205;
            8'd92: v = 14'd198;  8'd93: v = 14'd192;  8'd94: v = 14'd186;  8'd95: v = 14'd180;
            8'd96: v = 14'd174;  8'd97: v = 14'd169;  8'd98: v = 14'd164;  8'd99: v = 14'd159;
            8'd100: v = 14'd154; 8'd101: v = 14'd150; 8'd102: v = 14'd145; 8'd103: v = 14'd141;
            8'd104: v = 14'd136; 8'd105: v = 14'd132; 8'd106: v = 14'd129; 8'd107: v = 14'd125;
            8'd108: v = 14'd121; 8'd109: v = 14'd118; 8'd110: v = 14'd114;
            default: v = 14'd0;
        endcase
        return v;
    endfunction
endpackage

/* sv/ntc_thermistor_temperature.sv */
// ntc_thermistor_temperature: top level of the thermistor temperature block
// depends on ntc_pkg, ntc_front, ntc_queue, ntc_back
`timescale 1ns / 1ps
// Every sample is taken in one cycle; every SAMPLES-th transfer closes an
// average that is queued for the back end. The back end takes the average,
// then classifies and filters an open circuit average directly; a short or
// cold one first goes through a 26-step serial divide for the resistance.
// When it interpolates it takes the average, runs that divide, classifies,
// walks the resistance table one entry per cycle, runs a 16-step divide for
// the interpolation, clamps and filters; the result may wait for m_tready.
// Samples keep flowing while it works; only the closing sample stalls when two
// averages are already queued.
module ntc_thermistor_temperature #(
    parameter int SAMPLES_PER_AVERAGE = ntc_pkg::SamplesPerAverage,
    parameter int TABLE_ENTRIES       = ntc_pkg::TableEntries
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // adc_sample[9:0], machine_working[10], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // filtered_temperature[10:0], open_fault,
                                   // short_fault, shutdown_request, zero fill
);
    logic [9:0]    open_limit_reg;
    logic [15:0]   pullup_reg;
    logic          fj_valid, fj_ready, bj_valid, bj_ready;
    ntc_pkg::job_t fj, bj;
    logic [10:0]   temp;
    logic          open_f, short_f, shut;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_limit_reg <= ntc_pkg::OpenLimitReset;
            pullup_reg     <= ntc_pkg::PullupReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ntc_pkg::RegOpenLimit) open_limit_reg <= cfg_data[9:0];
            if (cfg_index == ntc_pkg::RegPullup)    pullup_reg <= cfg_data;
        end
    end

    ntc_front #(.SAMPLES(SAMPLES_PER_AVERAGE)) u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sample(s_tdata[9:0]), .working(s_tdata[10]),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    ntc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
        .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
    );

    ntc_back #(.ENTRIES(TABLE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .open_limit(open_limit_reg), .pull_scale(pullup_reg),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .temp(temp),
        .open_f(open_f), .short_f(short_f), .shut(shut)
    );

    assign m_tdata = {2'd0, shut, short_f, open_f, temp};
endmodule

/* sv/ntc_front.sv */
// ntc_front: accumulates samples and forms the average every SAMPLES-th transfer
// depends on ntc_pkg
`timescale 1ns / 1ps
module ntc_front #(
    parameter int SAMPLES = ntc_pkg::SamplesPerAverage
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [9:0]     sample,
    input  logic           working,
    output logic           job_valid,
    input  logic           job_ready,
    output ntc_pkg::job_t  job
);
    localparam int CW = $clog2(SAMPLES + 1);
    localparam int SW = 10 + $clog2(SAMPLES + 1);

    logic [CW-1:0] count_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_new;
    logic          last;
    logic          fire;

    // stall only on the sample that closes an average while the queue is full
    assign sum_new  = sum_reg + SW'(sample);
    assign last     = (count_reg == CW'(SAMPLES - 1));
    assign s_tready = !last || job_ready;
    assign fire     = s_tvalid && s_tready;

    assign job_valid   = s_tvalid && last;
    assign job.avg     = 10'(sum_new / SW'(SAMPLES));
    assign job.working = working;

    // running sum and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_new;
            end
        end
    end
endmodule

/* sv/ntc_queue.sv */
// ntc_queue: two-entry queue of averaged jobs between front and back
// depends on ntc_pkg
`timescale 1ns / 1ps
module ntc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ntc_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output ntc_pkg::job_t out_job
);
    ntc_pkg::job_t mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= in_job;
    end
endmodule

/* sv/ntc_back.sv */
// ntc_back: resistance division, table walk, interpolation and iir filter
// depends on ntc_pkg
`timescale 1ns / 1ps
module ntc_back #(
    parameter int ENTRIES = ntc_pkg::TableEntries
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [9:0]    open_limit,
    input  logic [15:0]   pull_scale,
    input  logic          job_valid,
    output logic          job_ready,
    input  ntc_pkg::job_t job,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [10:0]   temp,
    output logic          open_f,
    output logic          short_f,
    output logic          shut
);
    localparam int Bound = (ENTRIES < ntc_pkg::TableStored) ? ENTRIES : ntc_pkg::TableStored;

    typedef enum logic [2:0] {S_IDLE, S_DIV_R, S_CLASS, S_WALK, S_DIV_F, S_FILT, S_OUT} state_t;

    state_t        state_reg;
    logic [25:0]   num_reg;      // dividend, becomes quotient
    logic [15:0]   rem_reg;
    logic [15:0]   den_reg;
    logic [4:0]    bit_reg;
    logic [13:0]   r_reg;
    logic [7:0]    idx_reg;
    logic signed [11:0] raw_reg;
    logic signed [11:0] filt_reg;
    logic          open_reg, short_reg, work_reg;
    logic [10:0]   temp_reg;
    logic          ovalid_reg, ofault_reg, sfault_reg, shut_reg;

    logic [16:0]   rem_sh;
    logic [16:0]   rem_sub;
    logic [13:0]   tab_i, tab_p;
    logic [15:0]   quot14;
    logic signed [11:0] t_sum;
    logic signed [17:0] acc;

    assign job_ready = (state_reg == S_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign temp      = temp_reg;
    assign open_f    = ofault_reg;
    assign short_f   = sfault_reg;
    assign shut      = shut_reg;

    // restoring divider step
    assign rem_sh  = {rem_reg, num_reg[25]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign tab_i   = ntc_pkg::table_value(idx_reg);
    assign tab_p   = ntc_pkg::table_value(idx_reg - 8'd1);
    assign quot14  = num_reg[15:0] + 16'd1;
    assign t_sum   = $signed(12'(({4'd0, idx_reg} - 12'd1) * 12'd10)) - 12'sd100
                     + $signed({1'b0, quot14[10:0]});
    assign acc     = 18'sd13 * 18'(filt_reg) + 18'sd3 * 18'(raw_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            filt_reg   <= '0;
            ovalid_reg <= 1'b0;
            num_reg    <= '0;
            rem_reg    <= '0;
            den_reg    <= '0;
            bit_reg    <= '0;
            r_reg      <= '0;
            idx_reg    <= '0;
            raw_reg    <= '0;
            open_reg   <= 1'b0;
            short_reg  <= 1'b0;
            work_reg   <= 1'b0;
            temp_reg   <= '0;
            ofault_reg <= 1'b0;
            sfault_reg <= 1'b0;
            shut_reg   <= 1'b0;
        end
        else
        begin
            // result taken with nothing new behind it
            if (ovalid_reg && m_tready && state_reg != S_FILT) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        work_reg  <= job.working;
                        short_reg <= 1'b0;
                        open_reg  <= (job.avg >= open_limit);
                        num_reg   <= {10'd0, job.avg} * {10'd0, pull_scale};
                        den_reg   <= 16'd1024 - {6'd0, job.avg};
                        rem_reg   <= '0;
                        bit_reg   <= 5'd0;
                        state_reg <= (job.avg >= open_limit) ? S_CLASS : S_DIV_R;
                    end
                end
                S_DIV_R:
                begin
                    if (!rem_sub[16])
                        rem_reg <= rem_sub[15:0];
                    else
                        rem_reg <= rem_sh[15:0];
                    num_reg <= {num_reg[24:0], !rem_sub[16]};
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd25) state_reg <= S_CLASS;
                end
                S_CLASS:
                begin
                    idx_reg <= 8'd0;
                    if (open_reg || num_reg >= 26'(ntc_pkg::ColdLimit))
                    begin
                        r_reg   <= ntc_pkg::ColdLimit;
                        raw_reg <= -12'sd100;
                        state_reg <= S_FILT;
                    end
                    else if (num_reg[13:0] < ntc_pkg::HotLimit)
                    begin
                        short_reg <= 1'b1;
                        raw_reg   <= 12'sd1000;
                        state_reg <= S_FILT;
                    end
                    else
                    begin
                        r_reg     <= num_reg[13:0];
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // one table entry per cycle
                    if (idx_reg >= 8'(Bound))
                    begin
                        raw_reg   <= 12'sd1000;
                        state_reg <= S_FILT;
                    end
                    else if (r_reg <= tab_i)
                        idx_reg <= idx_reg + 8'd1;
                    else if (idx_reg == 8'd0)
                    begin
                        raw_reg   <= -12'sd100;
                        state_reg <= S_FILT;
                    end
                    else
                    begin
                        num_reg   <= 26'(10 * (tab_p - r_reg)) << 10;
                        den_reg   <= {2'd0, tab_p - tab_i};
                        rem_reg   <= '0;
                        bit_reg   <= 5'd10;
                        state_reg <= S_DIV_F;
                    end
                end
                S_DIV_F:
                begin
                    if (!rem_sub[16])
                        rem_reg <= rem_sub[15:0];
                    else
                        rem_reg <= rem_sh[15:0];
                    num_reg <= {num_reg[24:0], !rem_sub[16]};
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd25)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // clamp interpolated value
                    if (t_sum <= -12'sd100)     raw_reg <= -12'sd100;
                    else if (t_sum > 12'sd1000) raw_reg <= 12'sd1000;
                    else                        raw_reg <= t_sum;
                    state_reg <= S_FILT;
                end
                S_FILT:
                begin
                    if (!ovalid_reg || m_tready)
                    begin
                        filt_reg   <= acc[15:4];
                        temp_reg   <= acc[14:4];
                        ofault_reg <= open_reg;
                        sfault_reg <= short_reg;
                        shut_reg   <= (open_reg || short_reg) && work_reg;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* sv/ntc_checker.sv */
// ntc_checker: port-level checks for the thermistor block, bound to the top level
// depends on ntc_thermistor_temperature ports only
`timescale 1ns / 1ps
module ntc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    // shutdown only with a fault
    a_shut: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[11] || m_tdata[12]) else $error("shutdown w/o fault");
    // faults exclusive
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[11] && m_tdata[12])) else $error("both faults");
    // fill bits zero
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:14] == 2'd0) else $error("fill bits set");
endmodule

bind ntc_thermistor_temperature ntc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

/* tb/ntc_thermistor_temperature_tb.sv */
// ntc_thermistor_temperature_tb: self-checking bench for the thermistor temperature block
// drives adc samples over the slave stream, checks filtered temperature and fault flags
// depends on ntc_pkg and ntc_thermistor_temperature
`timescale 1ns / 1ps
module ntc_thermistor_temperature_tb;

    typedef struct packed {
        logic [9:0] adc;
        logic       working;
    } sample_t;

    typedef struct packed {
        logic [10:0] temp;
        logic        open_f;
        logic        short_f;
        logic        shutdown;
    } reading_t;

    localparam int IdleLimit = 20000;
    localparam int Settle    = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    ntc_thermistor_temperature dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor copy of block state and registers
    logic [9:0]  open_limit;
    logic [15:0] pullup_scale;
    logic [13:0] sum_acc;
    int          sum_count;
    int          filt;

    sample_t  pending_samples[$];
    reading_t expected_readings[$];
    int       error_count;
    int       idle_cycles;
    int       readings_seen;
    int       faults_seen;
    bit       calm;
    bit       hold_send;
    bit       timed_out;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // interpolated table temperature for a resistance
    function automatic int resistance_to_temp(input int r);
        int i;
        int hi;
        int lo;
        int t;
        i = 0;
        while (i < ntc_pkg::TableEntries && r <= int'(ntc_pkg::table_value(8'(i))))
            i++;
        if (i >= ntc_pkg::TableEntries)
            return 1000;
        if (i == 0)
            return -100;
        hi = int'(ntc_pkg::table_value(8'(i - 1)));
        lo = int'(ntc_pkg::table_value(8'(i)));
        t = -100 + (i - 1) * 10 + (10 * (hi - r)) / (hi - lo) + 1;
        if (t <= -100)
            t = -100;
        else if (t > 1000)
            t = 1000;
        return t;
    endfunction

    // accumulate one sample, queue a reading when the average closes
    task automatic predict_sample(input sample_t s);
        longint avg;
        longint r;
        int raw;
        int v;
        reading_t rd;
        sum_acc = sum_acc + 14'(s.adc);
        sum_count++;
        if (sum_count < ntc_pkg::SamplesPerAverage)
            return;
        avg = longint'(sum_acc) / ntc_pkg::SamplesPerAverage;
        sum_acc = '0;
        sum_count = 0;
        rd = '0;
        if (avg >= longint'(open_limit))
        begin
            rd.open_f = 1'b1;
            r = 9297;
        end
        else
        begin
            r = (avg * longint'(pullup_scale)) / (1024 - avg);
            if (r > 9297)
                r = 9297;
        end
        if (r >= 9297)
            raw = -100;
        else if (r < 114)
        begin
            rd.short_f = 1'b1;
            raw = 1000;
        end
        else
            raw = resistance_to_temp(int'(r));
        v = 13 * filt + 3 * raw;
        filt = v >>> 4;
        rd.temp = 11'(filt);
        rd.shutdown = (rd.open_f | rd.short_f) & s.working;
        expected_readings.push_back(rd);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_sample(pending_samples.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_samples.size() != 0 && !hold_send
                    && (calm || $urandom_range(99) >= 22))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, pending_samples[0].working, pending_samples[0].adc};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            m_tready <= calm || $urandom_range(99) >= 22;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                readings_seen++;
                if (expected_readings.size() == 0)
                    report_mismatch("unexpected reading", int'(m_tdata), -1);
                else
                begin
                    reading_t e;
                    e = expected_readings.pop_front();
                    if (m_tdata[10:0] != e.temp)
                        report_mismatch("filtered_temperature", int'($signed(m_tdata[10:0])),
                                        int'($signed(e.temp)));
                    if (m_tdata[11] != e.open_f)
                        report_mismatch("open_fault", m_tdata[11], e.open_f);
                    if (m_tdata[12] != e.short_f)
                        report_mismatch("short_fault", m_tdata[12], e.short_f);
                    if (m_tdata[13] != e.shutdown)
                        report_mismatch("shutdown_request", m_tdata[13], e.shutdown);
                    if (e.open_f | e.short_f)
                        faults_seen++;
                    if (m_tdata[15:14] != 2'b00)
                        report_mismatch("zero fill", m_tdata[15:14], 0);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (idle_cycles >= IdleLimit && !timed_out)
        begin
            timed_out = 1'b1;
            $display("timeout: no transfer for %0d cycles", IdleLimit);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sixteen samples sitting around a chosen average
    task automatic add_block(input int avg, input bit working, input bit spread);
        int k;
        int v;
        for (k = 0; k < ntc_pkg::SamplesPerAverage; k++)
        begin
            v = avg;
            if (spread)
            begin
                v = avg + ((k % 2) ? 7 : -7);
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
            end
            pending_samples.push_back({10'(v), working});
        end
    endtask

    // wait for all readings, let the back end settle, then write a register
    task automatic drain_and_write(input logic [0:0] idx, input logic [15:0] val);
        while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (Settle) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ntc_pkg::RegOpenLimit)
            open_limit = val[9:0];
        else
            pullup_scale = val;
    endtask

    // random phase: mostly averages spread across the table, some noise
    task automatic add_random(input int n_blocks);
        int b;
        int k;
        for (b = 0; b < n_blocks; b++)
        begin
            if ($urandom_range(9) < 7)
                add_block($urandom_range(1023), $urandom_range(1), $urandom_range(1));
            else
                for (k = 0; k < ntc_pkg::SamplesPerAverage; k++)
                    pending_samples.push_back({10'($urandom_range(1023)), 1'($urandom_range(1))});
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ntc_pkg::RegOpenLimit;
        cfg_data = '0;
        m_tready = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        open_limit = ntc_pkg::OpenLimitReset;
        pullup_scale = ntc_pkg::PullupReset;
        sum_acc = '0;
        sum_count = 0;
        filt = 0;
        error_count = 0;
        readings_seen = 0;
        faults_seen = 0;
        calm = 1'b0;
        hold_send = 1'b0;
        timed_out = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero, full scale, open limit edge, short, cold, mid
        pending_samples.push_back({10'd0, 1'b1});
        pending_samples.push_back({10'd1023, 1'b0});
        for (int k = 0; k < 14; k++)
            pending_samples.push_back({10'd0, 1'b0});
        add_block(999, 1, 0);
        add_block(1000, 1, 0);
        add_block(10, 1, 0);
        add_block(600, 0, 0);
        drain_and_write(ntc_pkg::RegOpenLimit, 16'd1);
        add_block(0, 1, 0);
        add_block(1, 1, 0);
        // pause the sender after the first block until its reading has come
        while (pending_samples.size() > ntc_pkg::SamplesPerAverage) @(posedge clk);
        hold_send = 1'b1;
        while (expected_readings.size() != 0 || s_tvalid) @(posedge clk);
        hold_send = 1'b0;
        drain_and_write(ntc_pkg::RegOpenLimit, 16'd1023);
        drain_and_write(ntc_pkg::RegPullup, 16'd1);
        add_block(1022, 1, 0);
        add_block(512, 0, 0);
        // last table entry: avg 512 with scale 114 gives a resistance of exactly 114
        drain_and_write(ntc_pkg::RegPullup, 16'd114);
        add_block(512, 1, 0);
        drain_and_write(ntc_pkg::RegPullup, 16'd65535);
        add_block(1, 1, 0);
        add_block(300, 0, 0);

        // random phases over several register settings
        drain_and_write(ntc_pkg::RegPullup, 16'd1594);
        drain_and_write(ntc_pkg::RegOpenLimit, 16'd1000);
        add_random(15);
        calm = 1'b1;
        add_random(8);
        while (pending_samples.size() != 0) @(posedge clk);
        calm = 1'b0;
        drain_and_write(ntc_pkg::RegPullup, 16'($urandom_range(65535, 1)));
        drain_and_write(ntc_pkg::RegOpenLimit, 16'($urandom_range(1023, 1)));
        add_random(15);
        drain_and_write(ntc_pkg::RegPullup, 16'($urandom_range(4000, 100)));
        drain_and_write(ntc_pkg::RegOpenLimit, 16'd1023);
        add_random(22);

        while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (Settle) @(posedge clk);
        $display("covered %0d readings, %0d with a fault, over several limit and scale settings",
                 readings_seen, faults_seen);
        if (error_count == 0 && expected_readings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* files.f */
sv/ntc_pkg.sv
sv/ntc_front.sv
sv/ntc_queue.sv
sv/ntc_back.sv
sv/ntc_thermistor_temperature.sv
sv/ntc_checker.sv
tb/ntc_thermistor_temperature_tb.sv
